@@ hw/rtl/siph_pkg.sv @@
// Shared types, constants and SipRound helpers for the nonce hash pipeline.
package siph_pkg;

   localparam int COMPRESS_ROUNDS = 2;
   localparam int FINAL_ROUNDS    = 4;
   localparam int WORD_WIDTH      = 64;
   localparam int NONCE_WIDTH     = 64;
   localparam int HASH_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int NUM_KEYS        = 4;

   // Constant folded into v2 ahead of the finalization rounds
   localparam logic [WORD_WIDTH-1:0] FINAL_XOR_CONST = 64'h0000_0000_0000_00ff;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_WORD0 = 2'd0,
      CSR_KEY_WORD1 = 2'd1,
      CSR_KEY_WORD2 = 2'd2,
      CSR_KEY_WORD3 = 2'd3
   } csr_index_type;

   // Hash state plus the nonce, which is needed again before finalization
   typedef struct packed {
      logic [WORD_WIDTH-1:0]  v0;
      logic [WORD_WIDTH-1:0]  v1;
      logic [WORD_WIDTH-1:0]  v2;
      logic [WORD_WIDTH-1:0]  v3;
      logic [NONCE_WIDTH-1:0] nonce;
   } siph_state_type;

   function automatic logic [WORD_WIDTH-1:0] rotl(input logic [WORD_WIDTH-1:0] x,
                                                  input int r);
      return (x << r) | (x >> (WORD_WIDTH - r));
   endfunction

   // First half of a SipRound: the two independent adds
   function automatic siph_state_type half_a(input siph_state_type s);
      siph_state_type        o;
      logic [WORD_WIDTH-1:0] a0;
      logic [WORD_WIDTH-1:0] a2;
      a0      = s.v0 + s.v1;
      a2      = s.v2 + s.v3;
      o.v1    = rotl(s.v1, 13) ^ a0;
      o.v0    = rotl(a0, 32);
      o.v3    = rotl(s.v3, 16) ^ a2;
      o.v2    = a2;
      o.nonce = s.nonce;
      return o;
   endfunction

   // Second half of a SipRound
   function automatic siph_state_type half_b(input siph_state_type s);
      siph_state_type        o;
      logic [WORD_WIDTH-1:0] c0;
      logic [WORD_WIDTH-1:0] c2;
      c0      = s.v0 + s.v3;
      c2      = s.v2 + s.v1;
      o.v0    = c0;
      o.v3    = rotl(s.v3, 21) ^ c0;
      o.v1    = rotl(s.v1, 17) ^ c2;
      o.v2    = rotl(c2, 32);
      o.nonce = s.nonce;
      return o;
   endfunction

endpackage

@@ hw/rtl/siph_if.sv @@
// Valid/ready channel interfaces for nonce requests and hash responses.
interface siph_req_if;
   logic                             valid;
   logic                             ready;
   logic [siph_pkg::NONCE_WIDTH-1:0] nonce;

   modport source (output valid, output nonce, input ready);
   modport sink   (input valid, input nonce, output ready);
endinterface

interface siph_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [siph_pkg::HASH_WIDTH-1:0] hash_low;

   modport source (output valid, output hash_low, input ready);
   modport sink   (input valid, input hash_low, output ready);
endinterface

@@ hw/rtl/siph_stage.sv @@
// One pipeline stage: half a SipRound with its own valid and stall control.
module siph_stage #(
   parameter bit SECOND_HALF = 1'b0,
   parameter bit INJECT      = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  siph_pkg::siph_state_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output siph_pkg::siph_state_type out_data
);

   logic                     valid_ff;
   logic                     valid_in;
   siph_pkg::siph_state_type state_ff;
   siph_pkg::siph_state_type state_in;
   siph_pkg::siph_state_type mixed;
   logic                     load;

   // Stage is free when empty or when its content moves on this cycle
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Nonce and constant fold at the start of finalization, then the half round
   always_comb begin
      mixed = in_data;
      if (INJECT) begin
         mixed.v0 = in_data.v0 ^ in_data.nonce;
         mixed.v2 = in_data.v2 ^ siph_pkg::FINAL_XOR_CONST;
      end
      state_in = SECOND_HALF ? siph_pkg::half_b(mixed) : siph_pkg::half_a(mixed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = state_ff;

endmodule

@@ hw/rtl/siphash24_nonce_hash.sv @@
// Top level: keyed SipHash-2-4 of one 64-bit nonce, fully pipelined.
// Each request passes one half round per stage, then the output register.
// Throughput: one nonce per cycle while the response side accepts; under
// backpressure each stage holds its item.
// Reset clears all stage valid bits, the response valid bit and the key words.
module siphash24_nonce_hash #(
   parameter int COMPRESS_ROUNDS = siph_pkg::COMPRESS_ROUNDS,
   parameter int FINAL_ROUNDS    = siph_pkg::FINAL_ROUNDS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   siph_req_if.sink                             req_if,
   siph_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [siph_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [siph_pkg::WORD_WIDTH-1:0]      csr_wdata
);

   localparam int NUM_STAGES   = 2 * (COMPRESS_ROUNDS + FINAL_ROUNDS);
   localparam int INJECT_STAGE = 2 * COMPRESS_ROUNDS;

   logic [siph_pkg::WORD_WIDTH-1:0] key_ff [siph_pkg::NUM_KEYS];
   logic [NUM_STAGES:0]             link_valid;
   logic [NUM_STAGES:0]             link_ready;
   siph_pkg::siph_state_type        link_data [NUM_STAGES+1];
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [siph_pkg::HASH_WIDTH-1:0] hash_ff;
   logic [siph_pkg::HASH_WIDTH-1:0] hash_in;
   logic                            rsp_load;
   siph_pkg::siph_state_type        last;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < siph_pkg::NUM_KEYS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (siph_pkg::csr_index_type'(csr_index))
            siph_pkg::CSR_KEY_WORD0: key_ff[0] <= csr_wdata;
            siph_pkg::CSR_KEY_WORD1: key_ff[1] <= csr_wdata;
            siph_pkg::CSR_KEY_WORD2: key_ff[2] <= csr_wdata;
            siph_pkg::CSR_KEY_WORD3: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Initial state from keys, nonce folded into v3
   assign link_valid[0] = req_if.valid;
   assign req_if.ready  = link_ready[0];
   assign link_data[0]  = {key_ff[0], key_ff[1], key_ff[2], key_ff[3] ^ req_if.nonce,
                           req_if.nonce};

   // Half-round stages
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      siph_stage #(
         .SECOND_HALF ((g % 2) == 1),
         .INJECT      (g == INJECT_STAGE)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_data   (link_data[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_data  (link_data[g+1])
      );
   end

   // Output register: fold the four words, keep the low half
   assign last                   = link_data[NUM_STAGES];
   assign link_ready[NUM_STAGES] = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load               = link_valid[NUM_STAGES] && link_ready[NUM_STAGES];
   assign rsp_valid_in           = link_ready[NUM_STAGES] ? link_valid[NUM_STAGES]
                                                          : rsp_valid_ff;
   assign hash_in = last.v0[siph_pkg::HASH_WIDTH-1:0] ^ last.v1[siph_pkg::HASH_WIDTH-1:0]
                  ^ last.v2[siph_pkg::HASH_WIDTH-1:0] ^ last.v3[siph_pkg::HASH_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         hash_ff <= hash_in;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.hash_low = hash_ff;

   // Checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

   a_first_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !link_valid[1] |-> req_if.ready)
      else $error("request stalled while first stage is empty");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!(|link_valid[NUM_STAGES:1]) && !rsp_valid_ff) |=> !rsp_if.valid)
      else $error("response appeared from an empty pipeline");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the keyed SipHash-2-4 nonce hash pipeline.
`timescale 1ns / 100ps

module tb;

   localparam int PIPE_LATENCY  =
      2 * (siph_pkg::COMPRESS_ROUNDS + siph_pkg::FINAL_ROUNDS) + 1;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 350;
   localparam int NUM_PHASES    = 5;

   typedef logic [3:0][siph_pkg::WORD_WIDTH-1:0] sip_words_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 csr_we    = 1'b0;
   logic [siph_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [siph_pkg::WORD_WIDTH-1:0]      csr_wdata = '0;

   logic                             req_valid = 1'b0;
   logic [siph_pkg::NONCE_WIDTH-1:0] req_nonce = '0;
   logic                             rsp_ready = 1'b0;

   siph_req_if req_ch ();
   siph_rsp_if rsp_ch ();

   assign req_ch.valid = req_valid;
   assign req_ch.nonce = req_nonce;
   assign rsp_ch.ready = rsp_ready;

   siphash24_nonce_hash dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Bench copy of the key registers, matching reset
   logic [siph_pkg::WORD_WIDTH-1:0] key_word [siph_pkg::NUM_KEYS] = '{default: '0};

   logic [siph_pkg::NONCE_WIDTH-1:0] nonce_pending_q [$];
   logic [siph_pkg::HASH_WIDTH-1:0]  hash_expected_q [$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_asked     = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int mismatch_count = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Rotate left via a doubled word
   function automatic logic [siph_pkg::WORD_WIDTH-1:0] rot_left(
         input logic [siph_pkg::WORD_WIDTH-1:0] x, input int amount);
      logic [2*siph_pkg::WORD_WIDTH-1:0] doubled;
      doubled = {x, x} << amount;
      return doubled[2*siph_pkg::WORD_WIDTH-1:siph_pkg::WORD_WIDTH];
   endfunction

   // One SipRound over the four state words
   function automatic sip_words_type sip_round(input sip_words_type w);
      w[0] = w[0] + w[1];
      w[1] = rot_left(w[1], 13) ^ w[0];
      w[0] = rot_left(w[0], 32);
      w[2] = w[2] + w[3];
      w[3] = rot_left(w[3], 16) ^ w[2];
      w[0] = w[0] + w[3];
      w[3] = rot_left(w[3], 21) ^ w[0];
      w[2] = w[2] + w[1];
      w[1] = rot_left(w[1], 17) ^ w[2];
      w[2] = rot_left(w[2], 32);
      return w;
   endfunction

   // Expected hash of one nonce under the current keys
   function automatic logic [siph_pkg::HASH_WIDTH-1:0] nonce_hash_low(
         input logic [siph_pkg::NONCE_WIDTH-1:0] nonce);
      sip_words_type                   w;
      logic [siph_pkg::WORD_WIDTH-1:0] folded;
      w[0] = key_word[0];
      w[1] = key_word[1];
      w[2] = key_word[2];
      w[3] = key_word[3] ^ nonce;
      for (int r = 0; r < siph_pkg::COMPRESS_ROUNDS; r++) w = sip_round(w);
      w[0] = w[0] ^ nonce;
      w[2] = w[2] ^ siph_pkg::FINAL_XOR_CONST;
      for (int r = 0; r < siph_pkg::FINAL_ROUNDS; r++) w = sip_round(w);
      folded = w[0] ^ w[1] ^ w[2] ^ w[3];
      return folded[siph_pkg::HASH_WIDTH-1:0];
   endfunction

   // Random nonce: mostly full-width, some bit walks and small values
   function automatic logic [siph_pkg::NONCE_WIDTH-1:0] pick_nonce();
      logic [siph_pkg::NONCE_WIDTH-1:0] one_hot;
      one_hot = 64'd1 << $urandom_range(siph_pkg::NONCE_WIDTH - 1);
      case ($urandom_range(7))
         0: begin
            return one_hot;
         end
         1: begin
            return ~one_hot;
         end
         2: begin
            return 64'($urandom_range(255));
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   function automatic logic [siph_pkg::WORD_WIDTH-1:0] pick_key();
      case ($urandom_range(9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   // Register write; the bench copy follows right away since the pipe is empty
   task automatic write_key(input siph_pkg::csr_index_type idx,
                            input logic [siph_pkg::WORD_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      key_word[idx] = value;
   endtask

   task automatic load_keys(input logic [siph_pkg::WORD_WIDTH-1:0] k0,
                            input logic [siph_pkg::WORD_WIDTH-1:0] k1,
                            input logic [siph_pkg::WORD_WIDTH-1:0] k2,
                            input logic [siph_pkg::WORD_WIDTH-1:0] k3);
      write_key(siph_pkg::CSR_KEY_WORD0, k0);
      write_key(siph_pkg::CSR_KEY_WORD1, k1);
      write_key(siph_pkg::CSR_KEY_WORD2, k2);
      write_key(siph_pkg::CSR_KEY_WORD3, k3);
   endtask

   // Wait until every nonce is hashed and returned, then let the pipe settle
   task automatic wait_drained();
      do @(negedge clock);
      while (nonce_pending_q.size() != 0 || req_valid || hash_expected_q.size() != 0);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   // Request driver: holds an offered nonce until its transfer
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ch.ready) begin
            hash_expected_q.push_back(nonce_hash_low(req_nonce));
            void'(nonce_pending_q.pop_front());
         end
         if (!(req_valid && !req_ch.ready)) begin
            offer = (nonce_pending_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            req_valid <= offer;
            if (offer) begin
               req_nonce <= nonce_pending_q[0];
            end
         end
      end
   end

   // Response ready: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Response monitor
   always @(posedge clock) begin
      logic [siph_pkg::HASH_WIDTH-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ready) begin
         if (hash_expected_q.size() == 0) begin
            $error("hash_low: unexpected transfer, got %h", rsp_ch.hash_low);
            mismatch_count++;
         end else begin
            want = hash_expected_q.pop_front();
            if (rsp_ch.hash_low !== want) begin
               $error("hash_low mismatch: expected %h, actual %h", want, rsp_ch.hash_low);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[siphash24_nonce_hash] ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus sequence
   initial begin
      logic [siph_pkg::NONCE_WIDTH-1:0] edge_nonce [8];
      edge_nonce = '{64'h0, '1, 64'h1, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_0000_00FF};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: keys at reset value, all ones, then mixed extremes
      @(negedge clock);
      foreach (edge_nonce[i]) nonce_pending_q.push_back(edge_nonce[i]);
      wait_drained();
      load_keys('1, '1, '1, '1);
      foreach (edge_nonce[i]) nonce_pending_q.push_back(edge_nonce[i]);
      wait_drained();
      load_keys(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, '0,
                64'h8000_0000_0000_0001);
      foreach (edge_nonce[i]) nonce_pending_q.push_back(edge_nonce[i]);
      wait_drained();

      // Random phases: random keys, all-zero keys in the last, idle patterns by phase mod 4
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES - 1) begin
            load_keys('0, '0, '0, '0);
         end else begin
            load_keys(pick_key(), pick_key(), pick_key(), pick_key());
         end
         @(negedge clock);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 76;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 76;
            end
            default: begin
               send_idle_pct = 24;
               rsp_stall_pct = 24;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) nonce_pending_q.push_back(pick_nonce());
         // Back up the pipe while nonces keep coming
         if (p == 0) begin
            hold_asked++;
         end
         wait_drained();
      end

      if (mismatch_count == 0 && hash_expected_q.size() == 0) begin
         $display("[siphash24_nonce_hash] OK");
      end else begin
         $display("[siphash24_nonce_hash] ERROR");
      end
      $finish;
   end

endmodule
